### hdl/f2f_pkg.sv
package f2f_pkg;

    localparam int FLOAT_W = 32;
    localparam int FIXED_W = 32;
    localparam int FRAC_W = 5;
    localparam int EXPO_W = 8;
    localparam int MANT_W = 23;
    localparam int SHIFT_W = 10;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W = 1;

    localparam logic [FRAC_W-1:0] FRAC_BITS_RESET = 5'd16;
    localparam logic [EXPO_W-1:0] EXPO_MAX = 8'd255;
    localparam logic [EXPO_W-1:0] EXPO_ZERO = 8'd0;
    localparam logic signed [SHIFT_W-1:0] SHIFT_BASE = 10'sd150;
    localparam logic signed [SHIFT_W-1:0] MAX_RIGHT = 10'sd23;
    localparam logic signed [SHIFT_W-1:0] MAX_LEFT = -10'sd7;
    localparam logic [FIXED_W-1:0] POS_SAT = 32'h7fff_ffff;
    localparam logic [FIXED_W-1:0] NEG_SAT = 32'h8000_0000;

    localparam logic [REG_IDX_W-1:0] REG_FRAC_BITS = 1'b0;

    typedef struct packed {
        logic [FRAC_W-1:0] frac_bits;
    } f2f_cfg_t;

endpackage

### hdl/f2f_cfg.sv
module f2f_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [f2f_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [f2f_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [f2f_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output f2f_pkg::f2f_cfg_t                cfg
);
    import f2f_pkg::*;

    logic [FRAC_W-1:0] frac_bits_reg;
    logic [FRAC_W-1:0] frac_bits_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic write_en;

    assign pready = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign write_en = psel && penable && pwrite && pready;

    always_comb
    begin
        frac_bits_next = frac_bits_reg;
        if (write_en && reg_idx == REG_FRAC_BITS)
        begin
            frac_bits_next = pwdata[FRAC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_bits_reg <= FRAC_BITS_RESET;
        end
        else
        begin
            frac_bits_reg <= frac_bits_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_FRAC_BITS: prdata = {{(APB_DATA_W-FRAC_W){1'b0}}, frac_bits_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.frac_bits = frac_bits_reg;

endmodule

### hdl/f2f_core.sv
module f2f_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  f2f_pkg::f2f_cfg_t              cfg,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [f2f_pkg::FLOAT_W-1:0]    s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [f2f_pkg::FIXED_W-1:0]    m_axis_tdata
);
    import f2f_pkg::*;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [FLOAT_W-1:0]   in_data_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [FIXED_W-1:0]   out_data_reg;
    logic                 out_load;
    logic                 in_load;

    logic                 sign;
    logic [EXPO_W-1:0]    expo;
    logic [MANT_W-1:0]    mant;
    logic [MANT_W:0]      mag;
    logic signed [SHIFT_W-1:0] shift;
    logic signed [SHIFT_W-1:0] left_amt;
    logic [FIXED_W-1:0]   mag_shifted;
    logic [FIXED_W-1:0]   result;

    // The result register takes a new item whenever it is empty or drained.
    assign out_load = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load = s_axis_tvalid && s_axis_tready;

    assign sign = in_data_reg[FLOAT_W-1];
    assign expo = in_data_reg[FLOAT_W-2:MANT_W];
    assign mant = in_data_reg[MANT_W-1:0];
    assign mag = {1'b1, mant};
    assign shift = SHIFT_BASE - $signed({2'b00, expo})
                   - $signed({{(SHIFT_W-FRAC_W){1'b0}}, cfg.frac_bits});
    assign left_amt = -shift;

    always_comb
    begin
        if (shift >= 0)
        begin
            mag_shifted = {{(FIXED_W-MANT_W-1){1'b0}}, mag >> shift[4:0]};
        end
        else
        begin
            mag_shifted = {{(FIXED_W-MANT_W-1){1'b0}}, mag} << left_amt[2:0];
        end
    end

    always_comb
    begin
        if (expo == EXPO_MAX)
        begin
            if (mant != '0)
            begin
                result = '0;
            end
            else
            begin
                result = sign ? NEG_SAT : POS_SAT;
            end
        end
        else if (expo == EXPO_ZERO || shift > MAX_RIGHT)
        begin
            result = '0;
        end
        else if (shift < MAX_LEFT)
        begin
            result = sign ? NEG_SAT : POS_SAT;
        end
        else
        begin
            result = sign ? (FIXED_W'(0) - mag_shifted) : mag_shifted;
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_data_reg <= s_axis_tdata;
        end
        if (out_load && in_valid_reg)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
    else $error("input stage stalled without a blocked result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && in_valid_reg && expo == EXPO_MAX && mant != '0)
        |=> (m_axis_tvalid && m_axis_tdata == '0))
    else $error("NaN did not convert to zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && in_valid_reg && expo == EXPO_ZERO)
        |=> (m_axis_tvalid && m_axis_tdata == '0))
    else $error("zero or denormal did not convert to zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && in_valid_reg && !sign && expo != EXPO_MAX)
        |=> !m_axis_tdata[FIXED_W-1])
    else $error("positive input gave a negative result");

endmodule

### hdl/float_to_fixed_converter.sv
// Converts IEEE 754 single-precision bit patterns into signed 32-bit
// fixed-point values with a programmable number of fraction bits.
// Items enter on the s_axis channel (tdata holds float_bits) and leave on
// the m_axis channel (tdata holds fixed_value), one result per item, in order.
// The frac_bits register sits at byte address 0 of the APB port and resets
// to 16; write it only while no items are in flight.
// An item passes through an input register and then a result register before
// its result is offered on m_axis.
// One item per cycle is sustained while m_axis_tready is high; the conversion
// is one pass of shift, compare and negate logic between those two registers.
// When the receiver stalls, the result register holds its item and the
// input register can still take one more item before s_axis_tready drops.
// Reset empties both registers and restores frac_bits.
module float_to_fixed_converter
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [f2f_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [f2f_pkg::APB_DATA_W-1:0] pwdata,
    output logic [f2f_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // float_bits [31:0]
    input  logic [f2f_pkg::FLOAT_W-1:0]    s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // fixed_value [31:0]
    output logic [f2f_pkg::FIXED_W-1:0]    m_axis_tdata
);
    import f2f_pkg::*;

    f2f_cfg_t cfg;

    f2f_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    f2f_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

### test/tb_float_to_fixed_converter.sv
module tb_float_to_fixed_converter;

    import f2f_pkg::*;

    localparam int N_ROWS = 24;
    localparam int N_PHASES = 8;
    localparam int PHASE_ITEMS = 125;
    localparam int SETTLE_CYCLES = 6;
    localparam logic [APB_ADDR_W-1:0] ADDR_FRAC_BITS = APB_ADDR_W'(4 * REG_FRAC_BITS);

    typedef struct {
        bit                 set_cfg;
        logic [31:0]        cfg_word;
        logic [FLOAT_W-1:0] float_bits;
        bit                 known;
        logic [FIXED_W-1:0] fixed_value;
    } dir_row_t;

    typedef struct {
        logic [FLOAT_W-1:0] float_bits;
        logic [FRAC_W-1:0]  frac_bits;
        logic [FIXED_W-1:0] fixed_value;
    } fixed_expect_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // float_bits [31:0]
    logic [FLOAT_W-1:0]    s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // fixed_value [31:0]
    logic [FIXED_W-1:0]    m_axis_tdata;

    fixed_expect_t         fixed_expect_q[$];
    logic [FRAC_W-1:0]     frac_now;
    int                    mismatch_cnt;
    bit                    quiet;

    dir_row_t dir_rows [0:N_ROWS-1] = '{
        '{1'b0, 32'h0, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{1'b0, 32'h0, 32'h8000_0000, 1'b1, 32'h0000_0000},
        '{1'b0, 32'h0, 32'h0000_0001, 1'b1, 32'h0000_0000},
        '{1'b0, 32'h0, 32'h807f_ffff, 1'b1, 32'h0000_0000},
        '{1'b0, 32'h0, 32'h7f80_0000, 1'b1, POS_SAT},
        '{1'b0, 32'h0, 32'hff80_0000, 1'b1, NEG_SAT},
        '{1'b0, 32'h0, 32'h7fc0_0000, 1'b1, 32'h0000_0000},
        '{1'b0, 32'h0, 32'hffff_ffff, 1'b1, 32'h0000_0000},
        '{1'b0, 32'h0, 32'h7f80_0001, 1'b1, 32'h0000_0000},
        '{1'b0, 32'h0, 32'h3f80_0000, 1'b1, 32'h0001_0000},
        '{1'b0, 32'h0, 32'hbf80_0000, 1'b1, 32'hffff_0000},
        '{1'b0, 32'h0, 32'h46ff_ffff, 1'b1, 32'h7fff_ff80},
        '{1'b0, 32'h0, 32'hc6ff_ffff, 1'b1, 32'h8000_0080},
        '{1'b0, 32'h0, 32'h4700_0000, 1'b1, POS_SAT},
        '{1'b0, 32'h0, 32'hc700_0000, 1'b1, NEG_SAT},
        '{1'b0, 32'h0, 32'h37ff_ffff, 1'b0, 32'h0000_0000},
        '{1'b0, 32'h0, 32'h377f_ffff, 1'b1, 32'h0000_0000},
        '{1'b1, 32'hffff_ffe0, 32'h3f80_0000, 1'b1, 32'h0000_0001},
        '{1'b0, 32'h0, 32'h4eff_ffff, 1'b0, 32'h0000_0000},
        '{1'b0, 32'h0, 32'h4f00_0000, 1'b1, POS_SAT},
        '{1'b0, 32'h0, 32'hcf00_0000, 1'b1, NEG_SAT},
        '{1'b1, 32'hffff_ffff, 32'h3f80_0000, 1'b1, POS_SAT},
        '{1'b0, 32'h0, 32'hbf00_0000, 1'b0, 32'h0000_0000},
        '{1'b0, 32'h0, 32'h0080_0000, 1'b1, 32'h0000_0000}
    };

    float_to_fixed_converter dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [FIXED_W-1:0] fixed_of_float(input logic [FLOAT_W-1:0] f,
                                                          input logic [FRAC_W-1:0] frac);
        logic [EXPO_W-1:0]  expo;
        logic [MANT_W-1:0]  mant;
        logic [FIXED_W-1:0] mag;
        logic [FIXED_W-1:0] sat;
        int                 sh;
        expo = f[30:23];
        mant = f[22:0];
        sat = f[31] ? NEG_SAT : POS_SAT;
        if (expo == EXPO_MAX)
            return (mant != '0) ? '0 : sat;
        if (expo == EXPO_ZERO)
            return '0;
        mag = {8'd0, 1'b1, mant};
        sh = int'(SHIFT_BASE) - int'(expo) - int'(frac);
        if (sh >= 0)
        begin
            if (sh > int'(MAX_RIGHT))
                return '0;
            mag = mag >> sh;
        end
        else
        begin
            if (sh < int'(MAX_LEFT))
                return sat;
            mag = mag << (-sh);
        end
        return f[31] ? -mag : mag;
    endfunction

    // Most patterns land in the window where the shift moves between flush and saturation.
    function automatic logic [FLOAT_W-1:0] pick_float(input logic [FRAC_W-1:0] frac);
        logic [FLOAT_W-1:0] f;
        int                 sel;
        int                 e;
        f = $urandom;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            f[30:23] = $urandom_range(0, 1) ? EXPO_MAX : EXPO_ZERO;
            if ($urandom_range(0, 3) == 0)
                f[22:0] = '0;
        end
        else if (sel <= 7)
        begin
            e = int'(SHIFT_BASE) - int'(frac) - (int'($urandom_range(0, 34)) - 9);
            if (e < 1)
                e = 1;
            if (e > 254)
                e = 254;
            f[30:23] = e[7:0];
        end
        return f;
    endfunction

    task automatic send_item(input logic [FLOAT_W-1:0] f, input bit known,
                             input logic [FIXED_W-1:0] typed_value);
        fixed_expect_t x;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= f;
        do
            @(posedge clk);
        while (!s_axis_tready);
        x.float_bits = f;
        x.frac_bits = frac_now;
        x.fixed_value = known ? typed_value : fixed_of_float(f, frac_now);
        fixed_expect_q.push_back(x);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (fixed_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_frac(input logic [31:0] word);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_FRAC_BITS;
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        frac_now = word[FRAC_W-1:0];
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (fixed_expect_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected item: fixed_value %h", m_axis_tdata);
            end
            else
            begin
                if (m_axis_tdata !== fixed_expect_q[0].fixed_value)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: float_bits %h frac_bits %0d expected %h got %h",
                                 fixed_expect_q[0].float_bits, fixed_expect_q[0].frac_bits,
                                 fixed_expect_q[0].fixed_value, m_axis_tdata);
                end
                void'(fixed_expect_q.pop_front());
            end
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    initial
    begin
        #8000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        logic [FRAC_W-1:0] frac;
        logic [31:0]       word;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        mismatch_cnt = 0;
        quiet = 1'b0;
        frac_now = FRAC_BITS_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
        begin
            if (dir_rows[i].set_cfg)
            begin
                drain();
                write_frac(dir_rows[i].cfg_word);
            end
            send_item(dir_rows[i].float_bits, dir_rows[i].known, dir_rows[i].fixed_value);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p == 0)
                frac = '0;
            else if (p == 1)
                frac = '1;
            else
                frac = $urandom_range(0, 31);
            word = $urandom;
            word[FRAC_W-1:0] = frac;
            drain();
            write_frac(word);
            if (p == N_PHASES - 1)
                quiet = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_item(pick_float(frac_now), 1'b0, '0);
        end

        drain();
        if (mismatch_cnt == 0 && fixed_expect_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
hdl/f2f_pkg.sv
hdl/f2f_cfg.sv
hdl/f2f_core.sv
hdl/float_to_fixed_converter.sv
test/tb_float_to_fixed_converter.sv
